/* rtl/assert_macros.svh */
// assertion macros shared by the decoder modules
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define A_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define A_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/b85_pkg.sv */
// shared types, constants and helpers for the base85 stream decoder
// no dependencies
`default_nettype none

package b85_pkg;

   localparam int GROUP_W = 26;   // a held partial group stays below 85^4

   localparam logic [7:0]  CHAR_FIRST = 8'h21;
   localparam logic [7:0]  CHAR_LAST  = 8'h75;
   localparam logic [7:0]  CHAR_Z     = 8'h7A;
   localparam logic [7:0]  CHAR_Y     = 8'h79;
   localparam logic [7:0]  DIGIT_BIAS = 8'd33;
   localparam logic [32:0] RADIX      = 33'd85;
   localparam logic [2:0]  LAST_POS   = 3'd4;
   localparam logic [31:0] ZERO_WORD  = 32'h0000_0000;
   localparam logic [31:0] SPACE_WORD = 32'h2020_2020;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SHORTCUT = 2'd1,
      STAT_OVERFLOW = 2'd2,
      STAT_LONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_WORD  = 2'd0,
      CMD_FLUSH = 2'd1,
      CMD_NOTE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      status_type status;
      logic       last_of_run;
      logic       stream_end;
   } rsp_type;

   // one queued command: a word to emit, a partial group to pad, or a status note
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  word;
      logic [2:0]   count;
      status_type   status;
      logic         eos;
   } cmd_type;

   // padding k digits of 'u' (84) gives v*85^k + 85^k - 1
   function automatic logic [19:0] pad_scale(input logic [2:0] digits);
      logic [19:0] scale;
      unique case (digits)
         3'd2:    scale = 20'd614125;
         3'd3:    scale = 20'd7225;
         3'd4:    scale = 20'd85;
         default: scale = 20'd1;
      endcase
      return scale;
   endfunction

endpackage

`default_nettype wire

/* rtl/b85_front.sv */
// front end: classifies characters, accumulates groups, issues at most one command per item
// depends on b85_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b85_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire b85_pkg::req_type req,
   output logic                  push,
   output b85_pkg::cmd_type      cmd
);

   logic [2:0]                   cnt_ff, cnt_in;
   logic [b85_pkg::GROUP_W-1:0]  gv_ff, gv_in;
   logic                         err_ff, err_in;
   logic                         is_digit, is_short, issue;
   logic [32:0]                  mac;

   always_comb begin
      is_digit = (req.char_in >= b85_pkg::CHAR_FIRST) && (req.char_in <= b85_pkg::CHAR_LAST);
      is_short = (req.char_in == b85_pkg::CHAR_Z) || (req.char_in == b85_pkg::CHAR_Y);
      mac      = 33'(gv_ff) * b85_pkg::RADIX + 33'(req.char_in - b85_pkg::DIGIT_BIAS);

      cnt_in = cnt_ff;
      gv_in  = gv_ff;
      err_in = err_ff;
      issue  = 1'b0;
      cmd        = '0;
      cmd.kind   = b85_pkg::CMD_NOTE;
      cmd.status = b85_pkg::STAT_OK;
      cmd.eos    = req.end_of_stream;

      if (!err_ff) begin
         if (is_short) begin
            issue = 1'b1;
            if (cnt_ff != 3'd0) begin
               cmd.status = b85_pkg::STAT_SHORTCUT;
               err_in     = 1'b1;
            end else begin
               cmd.kind  = b85_pkg::CMD_WORD;
               cmd.word  = (req.char_in == b85_pkg::CHAR_Z) ? b85_pkg::ZERO_WORD
                                                            : b85_pkg::SPACE_WORD;
               cmd.count = 3'd4;
            end
         end else if (is_digit) begin
            if (cnt_ff == b85_pkg::LAST_POS) begin
               issue = 1'b1;
               if (mac[32]) begin
                  cmd.status = b85_pkg::STAT_OVERFLOW;
                  err_in     = 1'b1;
               end else begin
                  cmd.kind  = b85_pkg::CMD_WORD;
                  cmd.word  = mac[31:0];
                  cmd.count = 3'd4;
               end
               cnt_in = 3'd0;
               gv_in  = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
               gv_in  = mac[b85_pkg::GROUP_W-1:0];
            end
         end
         // flush only when this item has not already produced something
         if (req.end_of_stream && !issue) begin
            issue = 1'b1;
            if (cnt_in == 3'd1) begin
               cmd.status = b85_pkg::STAT_LONE;
            end else if (cnt_in != 3'd0) begin
               cmd.kind  = b85_pkg::CMD_FLUSH;
               cmd.word  = 32'(gv_in);
               cmd.count = cnt_in;
            end
         end
      end else if (req.end_of_stream) begin
         issue = 1'b1;
      end

      if (req.end_of_stream) begin
         cnt_in = 3'd0;
         gv_in  = '0;
         err_in = 1'b0;
      end
   end

   assign push = accept && issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         gv_ff  <= '0;
         err_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         gv_ff  <= gv_in;
         err_ff <= err_in;
      end
   end

   `A_IMPLY(a_front_empty_group, cnt_ff == 3'd0, gv_ff == '0, "empty group holds a value")

endmodule

`default_nettype wire

/* rtl/b85_cmd_fifo.sv */
// command queue between the front end and the result serializer
// depends on b85_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b85_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire b85_pkg::cmd_type push_data,
   input  wire logic             pop,
   output b85_pkg::cmd_type      pop_data,
   output logic                  full,
   output logic                  not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b85_pkg::cmd_type  slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `A_IMPLY(a_fifo_no_overrun, push, !full || pop, "command pushed into a full queue")

endmodule

`default_nettype wire

/* rtl/b85_back.sv */
// back end: pads final groups and serializes commands into result items
// depends on b85_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b85_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire b85_pkg::cmd_type cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output b85_pkg::rsp_type      rsp_payload
);

   logic                 busy_ff;
   logic [2:0]           rem_ff;
   logic [31:0]          word_ff;
   logic                 data_ff;
   b85_pkg::status_type  status_ff;
   logic                 eos_ff;

   logic [19:0]          scale;
   logic [45:0]          padded;
   logic [2:0]           rem_in;
   logic [31:0]          word_in;
   logic                 data_in;
   b85_pkg::status_type  status_in;
   logic                 advance, done;

   assign advance = busy_ff && rsp_ready;
   assign done    = advance && (rem_ff == 3'd1);
   assign pop     = cmd_valid && (!busy_ff || done);

   always_comb begin
      scale  = b85_pkg::pad_scale(cmd.count);
      padded = 46'(cmd.word[b85_pkg::GROUP_W-1:0]) * 46'(scale) + 46'(scale - 20'd1);

      rem_in    = 3'd1;
      word_in   = '0;
      data_in   = 1'b0;
      status_in = cmd.status;
      unique case (cmd.kind)
         b85_pkg::CMD_WORD: begin
            rem_in    = cmd.count;
            word_in   = cmd.word;
            data_in   = 1'b1;
            status_in = b85_pkg::STAT_OK;
         end
         b85_pkg::CMD_FLUSH: begin
            if (|padded[45:32]) begin
               status_in = b85_pkg::STAT_OVERFLOW;
            end else begin
               rem_in    = cmd.count - 3'd1;
               word_in   = padded[31:0];
               data_in   = 1'b1;
               status_in = b85_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= 3'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         rem_ff  <= rem_in;
      end else if (advance) begin
         busy_ff <= !done;
         rem_ff  <= rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff   <= word_in;
         data_ff   <= data_in;
         status_ff <= status_in;
         eos_ff    <= cmd.eos;
      end else if (advance) begin
         word_ff   <= {word_ff[23:0], 8'h00};
      end
   end

   assign rsp_valid               = busy_ff;
   assign rsp_payload.out_byte    = word_ff[31:24];
   assign rsp_payload.byte_valid  = data_ff;
   assign rsp_payload.status      = status_ff;
   assign rsp_payload.last_of_run = (rem_ff == 3'd1);
   assign rsp_payload.stream_end  = eos_ff && (rem_ff == 3'd1);

   `A_IMPLY(a_back_rem_live, busy_ff, rem_ff != 3'd0, "busy with no results left")
   `A_IMPLY(a_back_note_single, busy_ff && !data_ff, rem_ff == 3'd1, "status note spans items")
   `A_NEXT(a_back_load, pop, busy_ff, "loaded command not presented")

endmodule

`default_nettype wire

/* rtl/base85_stream_decoder.sv */
// an item's command is stored in the queue, then loaded into the serializer's registers
// one item per cycle while the queue has room; an item with n results yields n result items
// the command queue (QUEUE_DEPTH entries) lets input run ahead of the output serializer
// reset (synchronous, active high) clears group state, error flag, queue and output
// top level of the base85 stream decoder; depends on b85_pkg, b85_front, b85_cmd_fifo, b85_back
`default_nettype none

module base85_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire b85_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output b85_pkg::rsp_type      rsp_payload
);

   logic             accept, push, pop, full, not_empty;
   b85_pkg::cmd_type push_cmd, pop_cmd;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   b85_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .cmd    (push_cmd)
   );

   b85_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .full      (full),
      .not_empty (not_empty)
   );

   b85_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (not_empty),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
